[hdl/ufs_pkg.sv]
// Shared types and constants for the UART frame serializer.
`default_nettype none

package ufs_pkg;

   // Payload widths
   localparam int WORD_W        = 16;
   localparam int HALVES_W      = 3;
   localparam int CSR_INDEX_W   = 8;
   localparam int CSR_DATA_W    = 8;
   localparam int NBITS_W       = 5;
   localparam int PARITY_W      = 2;
   localparam int MP_W          = 2;
   // Holds a segment count up to 31 data bits plus the multiprocessor bit
   localparam int CNT_W         = 6;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_DATA_BITS      = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_LSB_FIRST      = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_PARITY_MODE    = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_STOP_HALF_BITS = 8'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_INVERT         = 8'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_MP_MODE        = 8'd5;

   // Parity modes
   localparam logic [PARITY_W-1:0] PAR_NONE = 2'd0;
   localparam logic [PARITY_W-1:0] PAR_EVEN = 2'd1;
   localparam logic [PARITY_W-1:0] PAR_ODD  = 2'd2;

   // Multiprocessor modes
   localparam logic [MP_W-1:0] MP_NORMAL    = 2'd0;
   localparam logic [MP_W-1:0] MP_ADDR_ONE  = 2'd1;
   localparam logic [MP_W-1:0] MP_ADDR_ZERO = 2'd2;

   // Segment durations in half-bit periods
   localparam logic [HALVES_W-1:0] HALVES_BIT = 3'd2;
   localparam logic [HALVES_W-1:0] STOP_MIN   = 3'd2;
   localparam logic [HALVES_W-1:0] STOP_MAX   = 3'd4;

   // Effective frame settings, already clamped to legal values
   typedef struct packed {
      logic [NBITS_W-1:0]  nbits;
      logic                lsb_first;
      logic [PARITY_W-1:0] parity_mode;
      logic [HALVES_W-1:0] stop_halves;
      logic                invert;
      logic [MP_W-1:0]     mp_mode;
   } cfg_type;

   // Sequencer phases
   typedef enum logic [2:0] {
      PH_IDLE,
      PH_START,
      PH_DATA,
      PH_PARITY,
      PH_STOP
   } phase_type;

endpackage

`default_nettype wire

[hdl/ufs_channels.sv]
// Handshake channel interfaces for the UART frame serializer.
`default_nettype none

interface ufs_req_if;
   logic                       valid;
   logic                       ready;
   logic [ufs_pkg::WORD_W-1:0] word;
   logic                       is_address;

   modport source (output valid, word, is_address, input ready);
   modport sink   (input valid, word, is_address, output ready);
endinterface

interface ufs_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         line_level;
   logic [ufs_pkg::HALVES_W-1:0] half_periods;
   logic                         last;

   modport source (output valid, line_level, half_periods, last, input ready);
   modport sink   (input valid, line_level, half_periods, last, output ready);
endinterface

interface ufs_csr_if;
   logic                            valid;
   logic                            ready;
   logic [ufs_pkg::CSR_INDEX_W-1:0] index;
   logic [ufs_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hdl/ufs_csr_regs.sv]
// Configuration registers of the UART frame serializer, clamped on write.
`default_nettype none

module ufs_csr_regs #(
   parameter int MAX_DATA_BITS = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   ufs_csr_if.sink           csr,
   output ufs_pkg::cfg_type  cfg
);

   localparam int NBITS_RST = (MAX_DATA_BITS < 8) ? MAX_DATA_BITS : 8;

   localparam ufs_pkg::cfg_type CFG_RESET = '{
      nbits:       ufs_pkg::NBITS_W'(NBITS_RST),
      lsb_first:   1'b1,
      parity_mode: ufs_pkg::PAR_NONE,
      stop_halves: ufs_pkg::STOP_MIN,
      invert:      1'b0,
      mp_mode:     ufs_pkg::MP_NORMAL
   };

   ufs_pkg::cfg_type                cfg_ff;
   ufs_pkg::cfg_type                cfg_in;
   logic [ufs_pkg::NBITS_W-1:0]     nbits_wr;
   logic [ufs_pkg::PARITY_W-1:0]    parity_wr;
   logic [ufs_pkg::HALVES_W-1:0]    stop_wr;
   logic [ufs_pkg::MP_W-1:0]        mp_wr;

   // Writes are taken at any time
   assign csr.ready = 1'b1;
   assign cfg       = cfg_ff;

   // Clamp write data to the range the frame builder supports
   always_comb begin
      nbits_wr = csr.data[ufs_pkg::NBITS_W-1:0];
      if (nbits_wr == '0) begin
         nbits_wr = ufs_pkg::NBITS_W'(1);
      end else if (int'(nbits_wr) > MAX_DATA_BITS) begin
         nbits_wr = ufs_pkg::NBITS_W'(MAX_DATA_BITS);
      end

      parity_wr = csr.data[ufs_pkg::PARITY_W-1:0];
      if (parity_wr != ufs_pkg::PAR_EVEN && parity_wr != ufs_pkg::PAR_ODD) begin
         parity_wr = ufs_pkg::PAR_NONE;
      end

      stop_wr = csr.data[ufs_pkg::HALVES_W-1:0];
      if (stop_wr < ufs_pkg::STOP_MIN) begin
         stop_wr = ufs_pkg::STOP_MIN;
      end else if (stop_wr > ufs_pkg::STOP_MAX) begin
         stop_wr = ufs_pkg::STOP_MAX;
      end

      mp_wr = csr.data[ufs_pkg::MP_W-1:0];
      if (mp_wr != ufs_pkg::MP_ADDR_ONE && mp_wr != ufs_pkg::MP_ADDR_ZERO) begin
         mp_wr = ufs_pkg::MP_NORMAL;
      end
   end

   // Decode the register index; unknown indexes drop the write
   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid && csr.ready) begin
         case (csr.index)
            ufs_pkg::REG_DATA_BITS:      cfg_in.nbits       = nbits_wr;
            ufs_pkg::REG_LSB_FIRST:      cfg_in.lsb_first   = csr.data[0];
            ufs_pkg::REG_PARITY_MODE:    cfg_in.parity_mode = parity_wr;
            ufs_pkg::REG_STOP_HALF_BITS: cfg_in.stop_halves = stop_wr;
            ufs_pkg::REG_INVERT:         cfg_in.invert      = csr.data[0];
            ufs_pkg::REG_MP_MODE:        cfg_in.mp_mode     = mp_wr;
            default:                     cfg_in             = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

[hdl/ufs_seq.sv]
// Frame sequencer: bit register with a stepping index and the segment output register.
`default_nettype none

module ufs_seq #(
   parameter int MAX_DATA_BITS = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire ufs_pkg::cfg_type cfg,
   ufs_req_if.sink               req,
   ufs_rsp_if.source             rsp
);

   localparam int FW = MAX_DATA_BITS + 1;
   localparam int IW = $clog2(FW);
   localparam int WW = FW + ufs_pkg::WORD_W;

   ufs_pkg::phase_type            phase_ff, phase_in;
   logic [FW-1:0]                 frame_ff, frame_in;
   logic [IW-1:0]                 pos_ff, pos_in;
   logic [ufs_pkg::CNT_W-1:0]     rem_ff, rem_in;
   logic                          ones_ff, ones_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          line_level_ff, line_level_in;
   logic [ufs_pkg::HALVES_W-1:0]  half_periods_ff, half_periods_in;
   logic                          last_ff, last_in;

   logic                          take;
   logic                          advance;
   logic                          has_mp;
   logic                          mp_bit;
   logic                          cur_bit;
   logic [ufs_pkg::CNT_W-1:0]     total;
   logic [WW-1:0]                 word_wide;
   logic [FW-1:0]                 frame_load;

   assign req.ready        = (phase_ff == ufs_pkg::PH_IDLE);
   assign take             = req.valid && req.ready;
   assign advance          = !rsp_valid_ff || rsp.ready;

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.line_level   = line_level_ff;
   assign rsp.half_periods = half_periods_ff;
   assign rsp.last         = last_ff;

   // Build the frame bits: masked data word with the multiprocessor bit on top
   assign has_mp    = (cfg.mp_mode != ufs_pkg::MP_NORMAL);
   assign mp_bit    = (cfg.mp_mode == ufs_pkg::MP_ADDR_ONE) ? req.is_address
                                                            : !req.is_address;
   assign total     = ufs_pkg::CNT_W'(cfg.nbits) + ufs_pkg::CNT_W'(has_mp);
   assign word_wide = {{FW{1'b0}}, req.word};
   assign cur_bit   = frame_ff[pos_ff];

   always_comb begin
      for (int j = 0; j < FW; j++) begin
         if (j < int'(cfg.nbits)) begin
            frame_load[j] = word_wide[j];
         end else if (j == int'(cfg.nbits) && has_mp) begin
            frame_load[j] = mp_bit;
         end else begin
            frame_load[j] = 1'b0;
         end
      end
   end

   // Step through the frame one segment per output transfer
   always_comb begin
      phase_in        = phase_ff;
      frame_in        = frame_ff;
      pos_in          = pos_ff;
      rem_in          = rem_ff;
      ones_in         = ones_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp.ready;
      line_level_in   = line_level_ff;
      half_periods_in = half_periods_ff;
      last_in         = last_ff;

      case (phase_ff)
         ufs_pkg::PH_IDLE: begin
            if (take) begin
               frame_in = frame_load;
               pos_in   = cfg.lsb_first ? '0 : IW'(total - ufs_pkg::CNT_W'(1));
               rem_in   = total;
               ones_in  = 1'b0;
               phase_in = ufs_pkg::PH_START;
            end
         end
         ufs_pkg::PH_START: begin
            if (advance) begin
               rsp_valid_in    = 1'b1;
               line_level_in   = cfg.invert;
               half_periods_in = ufs_pkg::HALVES_BIT;
               last_in         = 1'b0;
               phase_in        = ufs_pkg::PH_DATA;
            end
         end
         ufs_pkg::PH_DATA: begin
            if (advance) begin
               rsp_valid_in    = 1'b1;
               line_level_in   = cur_bit ^ cfg.invert;
               half_periods_in = ufs_pkg::HALVES_BIT;
               last_in         = 1'b0;
               ones_in         = ones_ff ^ cur_bit;
               pos_in          = cfg.lsb_first ? pos_ff + IW'(1) : pos_ff - IW'(1);
               rem_in          = rem_ff - ufs_pkg::CNT_W'(1);
               if (rem_ff == ufs_pkg::CNT_W'(1)) begin
                  phase_in = (cfg.parity_mode != ufs_pkg::PAR_NONE) ? ufs_pkg::PH_PARITY
                                                                    : ufs_pkg::PH_STOP;
               end
            end
         end
         ufs_pkg::PH_PARITY: begin
            if (advance) begin
               rsp_valid_in    = 1'b1;
               line_level_in   = ones_ff ^ (cfg.parity_mode == ufs_pkg::PAR_ODD) ^ cfg.invert;
               half_periods_in = ufs_pkg::HALVES_BIT;
               last_in         = 1'b0;
               phase_in        = ufs_pkg::PH_STOP;
            end
         end
         ufs_pkg::PH_STOP: begin
            if (advance) begin
               rsp_valid_in    = 1'b1;
               line_level_in   = !cfg.invert;
               half_periods_in = cfg.stop_halves;
               last_in         = 1'b1;
               phase_in        = ufs_pkg::PH_IDLE;
            end
         end
         default: begin
            phase_in = ufs_pkg::PH_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= ufs_pkg::PH_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and working registers
   always_ff @(posedge clock) begin
      frame_ff        <= frame_in;
      pos_ff          <= pos_in;
      rem_ff          <= rem_in;
      ones_ff         <= ones_in;
      line_level_ff   <= line_level_in;
      half_periods_ff <= half_periods_in;
      last_ff         <= last_in;
   end

endmodule

`default_nettype wire

[hdl/uart_frame_serializer.sv]
// UART frame serializer top level: turns data words into line segments.
//
// Usage:
//   req_ch  - one transfer per frame: word and is_address.
//   rsp_ch  - one transfer per line segment: line_level, half_periods, last.
//             A frame is start, data bits, optional multiprocessor bit,
//             optional parity bit, then a stop segment flagged by last.
//   csr_ch  - register writes (index, data); always ready. Write only while
//             no frame is in flight.
// Timing: a taken request loads the frame register and enters the start phase,
//   from which the start segment is loaded into the output register; after
//   that one segment per clock while rsp_ch is ready. A frame has N segments
//   (3 to MAX_DATA_BITS + 4). The sequencer steps one bit index per data
//   segment and takes the next request once the stop segment is in the
//   output register.
// Reset: synchronous; clears the sequencer and the output valid and loads
//   8 data bits, LSB first, no parity, one stop bit, no inversion, normal mode.
// Stall: when rsp_ch is not ready the output register holds its segment and
//   the sequencer waits; req_ch stays not ready until the frame is finished.
`default_nettype none

module uart_frame_serializer #(
   parameter int MAX_DATA_BITS = 16
) (
   input wire logic clock,
   input wire logic reset,
   ufs_req_if.sink  req_ch,
   ufs_rsp_if.source rsp_ch,
   ufs_csr_if.sink  csr_ch
);

   ufs_pkg::cfg_type cfg;

   // Hold the frame settings
   ufs_csr_regs #(
      .MAX_DATA_BITS (MAX_DATA_BITS)
   ) u_csr_regs (
      .clock (clock),
      .reset (reset),
      .csr   (csr_ch),
      .cfg   (cfg)
   );

   // Sequence each frame into segments
   ufs_seq #(
      .MAX_DATA_BITS (MAX_DATA_BITS)
   ) u_seq (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

endmodule

`default_nettype wire
